// ----- rtl/core/lpb_pkg.sv -----
// Shared constants for the line prefetch pixel buffer.
// Used by lpb_bank and line_prefetch_pixel_buffer; depends on nothing.
package lpb_pkg;

  parameter int unsigned BANK_ADDR_BITS_DEFAULT = 6;
  parameter int unsigned NUM_BANKS   = 4;
  parameter int unsigned BANK_SEL_BITS = 2;
  parameter int unsigned WORD_BITS   = 64;
  parameter int unsigned PIXEL_BITS  = 16;
  parameter int unsigned COORD_BITS  = 12;
  parameter int unsigned FILL_BITS   = 9;
  parameter int unsigned HIST_BITS   = 4;
  parameter int unsigned FILL_LIMIT  = 96;
  parameter int unsigned COLUMN_STEP = 4;

  parameter logic [COORD_BITS-1:0] WIDTH_RESET  = 12'd3839;
  parameter logic [COORD_BITS-1:0] HEIGHT_RESET = 12'd2159;
  parameter logic [HIST_BITS-1:0]  PHASE_RESET  = 4'b0001;

  parameter logic CFG_WIDTH  = 1'b0;
  parameter logic CFG_HEIGHT = 1'b1;

endpackage

// ----- rtl/core/lpb_bank.sv -----
// One line store bank: single-port synchronous RAM, registered read data.
// Read returns the word held before a write at the same address.
// Depends on lpb_pkg.
module lpb_bank #(
  parameter int unsigned ADDR_BITS = lpb_pkg::BANK_ADDR_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic [ADDR_BITS-1:0]           addr,
  input  logic                           we,
  input  logic [lpb_pkg::WORD_BITS-1:0]  wdata,
  input  logic                           re,
  output logic [lpb_pkg::WORD_BITS-1:0]  rdata
);

  logic [lpb_pkg::WORD_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

// ----- rtl/core/line_prefetch_pixel_buffer.sv -----
// Line prefetch pixel buffer: fetch machine, four line store banks, pixel select.
// One item per cycle when the output side takes results; result of an item is
// the registered state before it, ready in the cycle after the item is accepted.
// After reset the banks are zeroed, one row of all banks per cycle,
// over all 2**BANK_ADDR_BITS rows (64 by default), with s_tready low meanwhile.
// Depends on lpb_pkg and lpb_bank.
module line_prefetch_pixel_buffer #(
  parameter int unsigned BANK_ADDR_BITS = lpb_pkg::BANK_ADDR_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // hsync_in, vsync_in, enable_in, fetch_accept, word_valid, word_data[63:0], zeros
  input  logic [71:0] s_tdata,
  input  logic        s_tlast,   // word_last
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // hsync_out, vsync_out, enable_out, pixel_rgb565[15:0], fetch_valid,
  // fetch_address[23:0], word_ready, zeros
  output logic [47:0] m_tdata
);

  localparam int unsigned SLOT_BITS = BANK_ADDR_BITS + lpb_pkg::BANK_SEL_BITS;
  localparam int unsigned CB = lpb_pkg::COORD_BITS;
  localparam int unsigned HB = lpb_pkg::HIST_BITS;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_REQUEST = 2'd1;
  localparam logic [1:0] ST_WRITING = 2'd2;

  logic hs, vs, en, accept_in, wvalid, wlast;
  logic [lpb_pkg::WORD_BITS-1:0] wdata;
  assign hs        = s_tdata[0];
  assign vs        = s_tdata[1];
  assign en        = s_tdata[2];
  assign accept_in = s_tdata[3];
  assign wvalid    = s_tdata[4];
  assign wdata     = s_tdata[68:5];
  assign wlast     = s_tlast;

  logic [CB-1:0] width_minus_one, height_minus_one;
  logic [HB-1:0] enable_history, hsync_history, vsync_history;
  logic [CB-1:0] write_row, write_column, write_row_next, write_column_next;
  logic [SLOT_BITS-1:0] write_slot, read_slot, write_slot_next, read_slot_next;
  logic [HB-1:0] pixel_phase, pixel_phase_next;
  logic [lpb_pkg::NUM_BANKS-1:0] bank_choice_delayed;
  logic [HB-1:0] phase_delayed;
  logic [lpb_pkg::FILL_BITS-1:0] fill_difference, fill_difference_next;
  logic [1:0] fetch_state, fetch_state_next;
  logic [2*CB-1:0] request_address, request_address_next;
  logic request_pending, request_pending_next;
  logic accepting_words, accepting_words_next;
  logic [lpb_pkg::PIXEL_BITS-1:0] pixel_register, pix;

  logic clearing;
  logic [BANK_ADDR_BITS-1:0] clear_count;

  logic accept;
  assign s_tready = !clearing && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  function automatic logic [SLOT_BITS-1:0] next_bank_start(input logic [SLOT_BITS-1:0] slot);
    logic [lpb_pkg::BANK_SEL_BITS-1:0] bank;
    bank = slot[SLOT_BITS-1 -: lpb_pkg::BANK_SEL_BITS] + 2'd1;
    return {bank, {BANK_ADDR_BITS{1'b0}}};
  endfunction

  // fetch machine and counters
  always_comb begin
    write_row_next       = write_row;
    write_column_next    = write_column;
    write_slot_next      = write_slot;
    read_slot_next       = read_slot;
    pixel_phase_next     = pixel_phase;
    fill_difference_next = fill_difference;
    fetch_state_next     = fetch_state;
    request_address_next = request_address;
    request_pending_next = request_pending;
    accepting_words_next = accepting_words;

    unique case (fetch_state)
      ST_IDLE: begin
        if (fill_difference[lpb_pkg::FILL_BITS-1] ||
            fill_difference <= lpb_pkg::FILL_BITS'(lpb_pkg::FILL_LIMIT)) begin
          request_pending_next = 1'b1;
          request_address_next = {write_row, write_column};
          fetch_state_next     = ST_REQUEST;
        end
      end
      ST_REQUEST: begin
        request_pending_next = 1'b1;
        accepting_words_next = 1'b0;
        if (request_pending && accept_in) begin
          request_pending_next = 1'b0;
          accepting_words_next = 1'b1;
          fetch_state_next     = ST_WRITING;
        end
      end
      ST_WRITING: begin
        if (wvalid) begin
          write_column_next = write_column + CB'(lpb_pkg::COLUMN_STEP);
          write_slot_next   = write_slot + 1'b1;
          if (wlast) begin
            if (write_column >= width_minus_one) begin
              write_column_next = '0;
              write_row_next    = (write_row >= height_minus_one) ? '0 : write_row + 1'b1;
              write_slot_next   = next_bank_start(write_slot);
            end
            accepting_words_next = 1'b0;
            fetch_state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        // unused code: stays until reset
      end
    endcase

    if (en) begin
      pixel_phase_next = {pixel_phase[HB-2:0], pixel_phase[HB-1]};
      if (pixel_phase[0]) begin
        read_slot_next = read_slot + 1'b1;
      end
    end else if (enable_history[0]) begin
      read_slot_next   = next_bank_start(read_slot);
      pixel_phase_next = lpb_pkg::PHASE_RESET;
    end

    if (wvalid && !pixel_phase[0]) begin
      fill_difference_next = fill_difference + 1'b1;
    end else if (!wvalid && pixel_phase[0] && en) begin
      fill_difference_next = fill_difference - 1'b1;
    end
  end

  // banks
  logic [lpb_pkg::WORD_BITS-1:0] bank_rdata [lpb_pkg::NUM_BANKS];
  logic [lpb_pkg::BANK_SEL_BITS-1:0] write_bank, read_bank;
  assign write_bank = write_slot[SLOT_BITS-1 -: lpb_pkg::BANK_SEL_BITS];
  assign read_bank  = read_slot[SLOT_BITS-1 -: lpb_pkg::BANK_SEL_BITS];

  for (genvar b = 0; b < lpb_pkg::NUM_BANKS; b++) begin : g_bank
    logic                          is_wbank;
    logic [BANK_ADDR_BITS-1:0]     addr;
    logic                          we;
    logic [lpb_pkg::WORD_BITS-1:0] bwdata;

    assign is_wbank = (write_bank == lpb_pkg::BANK_SEL_BITS'(b));
    assign addr   = clearing ? clear_count :
                    is_wbank ? write_slot[BANK_ADDR_BITS-1:0] : read_slot[BANK_ADDR_BITS-1:0];
    assign we     = clearing || (accept && wvalid && is_wbank);
    assign bwdata = clearing ? '0 : wdata;

    lpb_bank #(.ADDR_BITS(BANK_ADDR_BITS)) u_bank (
      .clk   (clk),
      .addr  (addr),
      .we    (we),
      .wdata (bwdata),
      .re    (accept),
      .rdata (bank_rdata[b])
    );
  end

  // pixel select from registered bank data
  always_comb begin
    logic [lpb_pkg::WORD_BITS-1:0] word;
    if (bank_choice_delayed[0]) word = bank_rdata[0];
    else if (bank_choice_delayed[1]) word = bank_rdata[1];
    else if (bank_choice_delayed[2]) word = bank_rdata[2];
    else word = bank_rdata[3];
    if (enable_history == '0) pix = '0;
    else if (phase_delayed[0]) pix = word[15:0];
    else if (phase_delayed[1]) pix = word[31:16];
    else if (phase_delayed[2]) pix = word[47:32];
    else pix = word[63:48];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_minus_one  <= lpb_pkg::WIDTH_RESET;
      height_minus_one <= lpb_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpb_pkg::CFG_WIDTH:  width_minus_one  <= cfg_data;
        lpb_pkg::CFG_HEIGHT: height_minus_one <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clear_count <= '0;
    end else if (clearing) begin
      clear_count <= clear_count + 1'b1;
      if (clear_count == {BANK_ADDR_BITS{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_history      <= '0;
      hsync_history       <= '0;
      vsync_history       <= '0;
      write_row           <= '0;
      write_column        <= '0;
      write_slot          <= '0;
      read_slot           <= '0;
      pixel_phase         <= lpb_pkg::PHASE_RESET;
      bank_choice_delayed <= '0;
      phase_delayed       <= '0;
      fill_difference     <= '0;
      fetch_state         <= ST_IDLE;
      request_address     <= '0;
      request_pending     <= 1'b0;
      accepting_words     <= 1'b0;
      pixel_register      <= '0;
    end else if (accept) begin
      enable_history      <= {enable_history[HB-2:0], en};
      hsync_history       <= {hsync_history[HB-2:0], hs};
      vsync_history       <= {vsync_history[HB-2:0], vs};
      write_row           <= write_row_next;
      write_column        <= write_column_next;
      write_slot          <= write_slot_next;
      read_slot           <= read_slot_next;
      pixel_phase         <= pixel_phase_next;
      bank_choice_delayed <= lpb_pkg::NUM_BANKS'(1) << read_bank;
      phase_delayed       <= pixel_phase;
      fill_difference     <= fill_difference_next;
      fetch_state         <= fetch_state_next;
      request_address     <= request_address_next;
      request_pending     <= request_pending_next;
      accepting_words     <= accepting_words_next;
      pixel_register      <= pix;
    end
  end

  // output register: result is the state seen by the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, accepting_words, request_address, request_pending,
                  pixel_register, enable_history[1], vsync_history[1], hsync_history[1]};
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("item accepted during bank clear");

  a_words_in_writing: assert property (@(posedge clk) disable iff (rst)
    accepting_words |-> fetch_state == ST_WRITING)
    else $error("word_ready outside writing state");

  a_pending_in_request: assert property (@(posedge clk) disable iff (rst)
    request_pending |-> fetch_state == ST_REQUEST)
    else $error("fetch_valid outside request state");

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(pixel_phase))
    else $error("pixel phase not one-hot");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(fetch_state) && $stable(write_slot))
    else $error("state moved without an item");
`endif

endmodule
